FILE: rtl/ps2dec_pkg.sv
// Package for the PS/2 set 1 scan code decoder.
// Holds the result type, scan code constants and the ASCII lookup function.
// No dependencies.
package ps2dec_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 6;

	localparam logic [7:0] SC_NONE       = 8'h00;
	localparam logic [7:0] SC_BACKSPACE  = 8'h0E;
	localparam logic [7:0] SC_LSHIFT_MK  = 8'h2A;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_PREFIX     = 8'hE0;
	localparam logic [7:0] SC_RIGHT      = 8'h4D;
	localparam logic [7:0] SC_LEFT       = 8'h4B;
	localparam logic [7:0] SC_LEFT_BRK   = 8'hCB;
	localparam logic [7:0] SC_RIGHT_BRK  = 8'hCD;
	localparam logic [7:0] SC_DOWN       = 8'h50;
	localparam logic [7:0] SC_UP         = 8'h48;
	localparam logic [7:0] SC_DOWN_BRK   = 8'hD0;
	localparam logic [7:0] SC_UP_BRK     = 8'hC8;

	localparam logic CURSOR_RIGHT = 1'b0;
	localparam logic CURSOR_LEFT  = 1'b1;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       backspace_event;
		logic       cursor_event;
		logic       cursor_direction;
	} result_t;

	function automatic logic [7:0] to_ascii(input logic [7:0] code, input logic shifted);
		logic [7:0] p;
		logic [7:0] s;
		p = 8'h00;
		s = 8'h00;
		unique case (code)
			8'h02: begin p = "1"; s = "!"; end
			8'h03: begin p = "2"; s = 8'h22; end
			8'h04: begin p = "3"; s = 8'hA3; end
			8'h05: begin p = "4"; s = "$"; end
			8'h06: begin p = "5"; s = "%"; end
			8'h07: begin p = "6"; s = "^"; end
			8'h08: begin p = "7"; s = "&"; end
			8'h09: begin p = "8"; s = "*"; end
			8'h0A: begin p = "9"; s = "("; end
			8'h0B: begin p = "0"; s = ")"; end
			8'h0D: begin p = "="; s = "+"; end
			8'h10: begin p = "q"; s = "Q"; end
			8'h11: begin p = "w"; s = "W"; end
			8'h12: begin p = "e"; s = "E"; end
			8'h13: begin p = "r"; s = "R"; end
			8'h14: begin p = "t"; s = "T"; end
			8'h15: begin p = "y"; s = "Y"; end
			8'h16: begin p = "u"; s = "U"; end
			8'h17: begin p = "i"; s = "I"; end
			8'h18: begin p = "o"; s = "O"; end
			8'h19: begin p = "p"; s = "P"; end
			8'h1A: begin p = "["; s = "{"; end
			8'h1B: begin p = "]"; s = "}"; end
			8'h1C: begin p = 8'h0A; s = 8'h0A; end
			8'h1E: begin p = "a"; s = "A"; end
			8'h1F: begin p = "s"; s = "S"; end
			8'h20: begin p = "d"; s = "D"; end
			8'h21: begin p = "f"; s = "F"; end
			8'h22: begin p = "g"; s = "G"; end
			8'h23: begin p = "h"; s = "H"; end
			8'h24: begin p = "j"; s = "J"; end
			8'h25: begin p = "k"; s = "K"; end
			8'h26: begin p = "l"; s = "L"; end
			8'h2C: begin p = "z"; s = "Z"; end
			8'h2D: begin p = "x"; s = "X"; end
			8'h2E: begin p = "c"; s = "C"; end
			8'h2F: begin p = "v"; s = "V"; end
			8'h30: begin p = "b"; s = "B"; end
			8'h31: begin p = "n"; s = "N"; end
			8'h32: begin p = "m"; s = "M"; end
			8'h39: begin p = " "; s = " "; end
			default: begin p = 8'h00; s = 8'h00; end
		endcase
		return shifted ? s : p;
	endfunction

endpackage

FILE: rtl/ps2dec_in_if.sv
// Scan code input channel: valid/ready handshake with one byte payload.
// No dependencies.
interface ps2dec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] scan_code;

	modport source(output valid, output scan_code, input ready);
	modport sink(input valid, input scan_code, output ready);
endinterface

FILE: rtl/ps2dec_out_if.sv
// Decoded result channel: valid/ready handshake with character and event flags.
// No dependencies.
interface ps2dec_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] ascii_char;
	logic       backspace_event;
	logic       cursor_event;
	logic       cursor_direction;

	modport source(output valid, output ascii_char, output backspace_event,
		output cursor_event, output cursor_direction, input ready);
	modport sink(input valid, input ascii_char, input backspace_event,
		input cursor_event, input cursor_direction, output ready);
endinterface

FILE: rtl/ps2_set1_scancode_decoder.sv
// PS/2 scan code set 1 decoder, top level.
// Depends on ps2dec_pkg, ps2dec_in_if, ps2dec_out_if, ps2dec_core, ps2dec_outreg.
//
// Usage:
//   scan   - sink channel, one keyboard byte per transaction (valid/ready).
//   result - source channel, exactly one result per accepted byte: the
//            decoded ASCII character (0 when none), a backspace flag, and a
//            cursor event with its direction (0 right, 1 left).
//   A byte is registered on acceptance and decoded from the input register
//   into the result register when that register is free. One byte per cycle
//   is sustained while result.ready stays high; the shift/prefix/queue state
//   updates in the same cycle the byte is decoded.
//   Reset clears shift, the prefix flag, the code queue and both pipeline
//   valid bits. When the receiver stalls, the result register holds and the
//   input register keeps one more byte; scan.ready drops only when both are
//   full and result.ready is low.
module ps2_set1_scancode_decoder import ps2dec_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	ps2dec_in_if.sink    scan,
	ps2dec_out_if.source result
);
	logic       valid_s1;
	logic [7:0] code_s1;
	logic       free;
	logic       advance;
	result_t    res;

	assign advance    = valid_s1 && free;
	assign scan.ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			code_s1 <= scan.scan_code;
		end
	end

	ps2dec_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.code  (code_s1),
		.res   (res)
	);

	ps2dec_outreg u_outreg (
		.clk   (clk),
		.arst_n(arst_n),
		.load  (advance),
		.d     (res),
		.free  (free),
		.result(result)
	);

	a_bksp_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.backspace_event |-> result.ascii_char == 8'h00)
		else $error("backspace result carries a character");

	a_cursor_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.cursor_event |->
			result.ascii_char == 8'h00 && !result.backspace_event)
		else $error("cursor result carries a character or backspace");

	a_dir_only_on_event: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.cursor_event |-> !result.cursor_direction)
		else $error("cursor direction set without cursor event");

	a_advance_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.valid)
		else $error("decoded byte did not reach the result register");

endmodule

FILE: rtl/ps2dec_core.sv
// Decoder state (shift, prefix flag, code queue) and per-byte decode logic.
// Depends on ps2dec_pkg.
module ps2dec_core import ps2dec_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] code,
	output result_t    res
);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          shift_q;
	logic          prefix_q;
	logic [7:0]    first_q;
	logic [7:0]    second_q;
	logic [CW-1:0] count_q;

	logic          shift_n;
	logic          prefix_n;
	logic [7:0]    first_n;
	logic [7:0]    second_n;
	logic [CW-1:0] count_n;
	logic [7:0]    single;

	always_comb begin
		first_n  = first_q;
		second_n = second_q;
		count_n  = count_q;
		prefix_n = prefix_q;
		shift_n  = shift_q;
		res      = '0;
		single   = SC_NONE;

		// enqueue, or drop and flush when full
		if (code != SC_NONE) begin
			if (count_q != CW'(QUEUE_DEPTH)) begin
				if (count_q == CW'(0))
					first_n = code;
				else if (count_q == CW'(1))
					second_n = code;
				count_n = count_q + CW'(1);
			end else begin
				first_n  = SC_NONE;
				second_n = SC_NONE;
				count_n  = '0;
				prefix_n = 1'b0;
			end
		end

		unique case (code)
			SC_PREFIX: prefix_n = 1'b1;
			SC_LEFT, SC_RIGHT, SC_LEFT_BRK, SC_RIGHT_BRK,
			SC_DOWN, SC_UP, SC_DOWN_BRK, SC_UP_BRK: prefix_n = 1'b0;
			default: ;
		endcase

		if (count_n < CW'(2)) begin
			single = (count_n == CW'(0)) ? SC_NONE : first_n;
			res.ascii_char = to_ascii(single, shift_q);
			if (single == SC_BACKSPACE) begin
				res.backspace_event = 1'b1;
				res.ascii_char      = 8'h00;
			end else if (single == SC_LSHIFT_MK) begin
				shift_n = 1'b1;
			end else if (single == SC_LSHIFT_BRK) begin
				shift_n = 1'b0;
			end
		end else if (first_n == SC_PREFIX) begin
			if (second_n == SC_RIGHT) begin
				res.cursor_event     = 1'b1;
				res.cursor_direction = CURSOR_RIGHT;
			end else if (second_n == SC_LEFT) begin
				res.cursor_event     = 1'b1;
				res.cursor_direction = CURSOR_LEFT;
			end
		end

		if (!prefix_n) begin
			first_n  = SC_NONE;
			second_n = SC_NONE;
			count_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			prefix_q <= 1'b0;
			first_q  <= SC_NONE;
			second_q <= SC_NONE;
			count_q  <= '0;
		end else if (step) begin
			shift_q  <= shift_n;
			prefix_q <= prefix_n;
			first_q  <= first_n;
			second_q <= second_n;
			count_q  <= count_n;
		end
	end

endmodule

FILE: rtl/ps2dec_outreg.sv
// Result register driving the output channel; holds while the sink stalls.
// Depends on ps2dec_pkg and ps2dec_out_if.
module ps2dec_outreg import ps2dec_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  result_t             d,
	output logic                free,
	ps2dec_out_if.source        result
);
	logic    valid_q;
	result_t data_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			data_q <= d;
		end
	end

	assign result.valid            = valid_q;
	assign result.ascii_char       = data_q.ascii_char;
	assign result.backspace_event  = data_q.backspace_event;
	assign result.cursor_event     = data_q.cursor_event;
	assign result.cursor_direction = data_q.cursor_direction;

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for ps2_set1_scancode_decoder: directed and random scan code traffic,
// checked transaction by transaction against a behavioral predictor.
// Depends on ps2dec_pkg, ps2dec_in_if, ps2dec_out_if and the decoder RTL.
module tb_top;
	import ps2dec_pkg::*;

	localparam int CODE_QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int DRAIN_CYCLES     = 10;
	localparam int HOLD_OFF_CYCLES  = 200;

	logic clk;
	logic arst_n;

	ps2dec_in_if  scan();
	ps2dec_out_if result();

	ps2_set1_scancode_decoder #(.QUEUE_DEPTH(CODE_QUEUE_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.scan(scan),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	logic [7:0] scan_pending[$];
	result_t    pending_results[$];
	int         mismatches = 0;
	int         cycle_count = 0;
	int         sender_idle_pct = 0;
	int         receiver_stall_pct = 0;
	bit         receiver_hold = 1'b0;
	bit         scan_fire = 1'b0;

	// predictor state
	logic [7:0] plain_chars[256];
	logic [7:0] shifted_chars[256];
	bit         shift_down;
	bit         in_prefix;
	logic [7:0] head_code;
	logic [7:0] next_code;
	int         code_count;

	task automatic load_row(input int base, input string plain, input string shifted);
		for (int i = 0; i < plain.len(); i++) begin
			plain_chars[base + i]   = plain[i];
			shifted_chars[base + i] = shifted[i];
		end
	endtask

	function automatic void drop_codes();
		head_code  = SC_NONE;
		next_code  = SC_NONE;
		code_count = 0;
		in_prefix  = 1'b0;
	endfunction

	function automatic result_t decode_scan_byte(input logic [7:0] code);
		result_t    r;
		logic [7:0] c;
		r = '0;
		if (code != SC_NONE) begin
			if (code_count < CODE_QUEUE_DEPTH) begin
				if (code_count == 0)
					head_code = code;
				else if (code_count == 1)
					next_code = code;
				code_count++;
			end else begin
				drop_codes();
			end
		end
		case (code)
			SC_PREFIX: in_prefix = 1'b1;
			SC_LEFT, SC_RIGHT, SC_LEFT_BRK, SC_RIGHT_BRK,
			SC_DOWN, SC_UP, SC_DOWN_BRK, SC_UP_BRK: in_prefix = 1'b0;
			default: ;
		endcase
		if (code_count < 2) begin
			c = (code_count == 0) ? SC_NONE : head_code;
			r.ascii_char = shift_down ? shifted_chars[c] : plain_chars[c];
			if (c == SC_BACKSPACE) begin
				r.backspace_event = 1'b1;
				r.ascii_char = 8'h00;
			end else if (c == SC_LSHIFT_MK) begin
				shift_down = 1'b1;
			end else if (c == SC_LSHIFT_BRK) begin
				shift_down = 1'b0;
			end
		end else if (head_code == SC_PREFIX) begin
			if (next_code == SC_RIGHT) begin
				r.cursor_event = 1'b1;
				r.cursor_direction = CURSOR_RIGHT;
			end else if (next_code == SC_LEFT) begin
				r.cursor_event = 1'b1;
				r.cursor_direction = CURSOR_LEFT;
			end
		end
		if (!in_prefix)
			drop_codes();
		return r;
	endfunction

	function automatic logic [7:0] pick_closer(input int sel);
		case (sel)
			0: return SC_RIGHT;
			1: return SC_LEFT;
			2: return SC_RIGHT_BRK;
			3: return SC_LEFT_BRK;
			4: return SC_DOWN;
			5: return SC_UP;
			6: return SC_DOWN_BRK;
			default: return SC_UP_BRK;
		endcase
	endfunction

	task automatic add_keyboard_traffic(input int count);
		int added;
		int kind;
		int run;
		added = 0;
		while (added < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				scan_pending.push_back(8'($urandom_range(8'h01, 8'h3A)));
				added++;
			end else if (kind < 45) begin
				scan_pending.push_back(8'($urandom_range(8'h01, 8'h3A)) | 8'h80);
				added++;
			end else if (kind < 53) begin
				scan_pending.push_back(SC_LSHIFT_MK);
				added++;
			end else if (kind < 59) begin
				scan_pending.push_back(SC_LSHIFT_BRK);
				added++;
			end else if (kind < 64) begin
				scan_pending.push_back(SC_BACKSPACE);
				added++;
			end else if (kind < 81) begin
				scan_pending.push_back(SC_PREFIX);
				scan_pending.push_back(pick_closer($urandom_range(0, 7)));
				added += 2;
			end else if (kind < 88) begin
				// long or overflowing prefixed sequence
				scan_pending.push_back(SC_PREFIX);
				run = $urandom_range(1, 7);
				for (int i = 0; i < run; i++)
					scan_pending.push_back(8'($urandom_range(1, 255)));
				if ($urandom_range(0, 1))
					scan_pending.push_back(pick_closer($urandom_range(0, 7)));
				added += run + 1;
			end else if (kind < 93) begin
				scan_pending.push_back(SC_NONE);
				added++;
			end else begin
				scan_pending.push_back(8'($urandom_range(0, 255)));
				added++;
			end
		end
	endtask

	task automatic wait_input_drained();
		while (scan_pending.size() > 0 || scan.valid === 1'b1)
			@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		add_keyboard_traffic(count);
		wait_input_drained();
	endtask

	// input driver and receiver
	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			scan.valid   <= 1'b0;
			result.ready <= 1'b0;
		end else begin
			if (scan.valid !== 1'b1 || scan_fire) begin
				if (scan_pending.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					scan.valid     <= 1'b1;
					scan.scan_code <= scan_pending.pop_front();
				end else begin
					scan.valid     <= 1'b0;
					scan.scan_code <= 8'($urandom_range(0, 255));
				end
			end
			if (receiver_hold)
				result.ready <= 1'b0;
			else
				result.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
		end
	end

	// monitor: predicts on accepted input, checks accepted output
	always @(posedge clk) begin : monitor
		result_t seen;
		result_t want;
		scan_fire = (arst_n === 1'b1) && (scan.valid === 1'b1) && (scan.ready === 1'b1);
		if (scan_fire)
			pending_results.push_back(decode_scan_byte(scan.scan_code));
		if (arst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1) begin
			seen.ascii_char       = result.ascii_char;
			seen.backspace_event  = result.backspace_event;
			seen.cursor_event     = result.cursor_event;
			seen.cursor_direction = result.cursor_direction;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got %h", $time, seen);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (seen.ascii_char !== want.ascii_char) begin
					$display("%0t: ascii_char expected %h got %h",
						$time, want.ascii_char, seen.ascii_char);
					mismatches++;
				end
				if (seen.backspace_event !== want.backspace_event) begin
					$display("%0t: backspace_event expected %b got %b",
						$time, want.backspace_event, seen.backspace_event);
					mismatches++;
				end
				if (seen.cursor_event !== want.cursor_event) begin
					$display("%0t: cursor_event expected %b got %b",
						$time, want.cursor_event, seen.cursor_event);
					mismatches++;
				end
				if (seen.cursor_direction !== want.cursor_direction) begin
					$display("%0t: cursor_direction expected %b got %b",
						$time, want.cursor_direction, seen.cursor_direction);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		scan.valid     = 1'b0;
		scan.scan_code = 8'h00;
		result.ready   = 1'b0;

		for (int i = 0; i < 256; i++) begin
			plain_chars[i]   = 8'h00;
			shifted_chars[i] = 8'h00;
		end
		load_row(8'h02, "1234567890", "!\"#$%^&*()");
		load_row(8'h0D, "=", "+");
		load_row(8'h10, "qwertyuiop[]\n", "QWERTYUIOP{}\n");
		load_row(8'h1E, "asdfghjkl", "ASDFGHJKL");
		load_row(8'h2C, "zxcvbnm", "ZXCVBNM");
		load_row(8'h39, " ", " ");
		shifted_chars[8'h04] = 8'hA3;
		shift_down = 1'b0;
		drop_codes();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, shift, pound, backspace, cursor pairs, zero in prefix, overflow
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		scan_pending = '{8'h00, 8'hFF, 8'h10, 8'h04, SC_LSHIFT_MK, 8'h04, 8'h1E,
			SC_BACKSPACE, SC_LSHIFT_BRK, 8'h1E, 8'h3A,
			SC_PREFIX, SC_RIGHT, SC_PREFIX, SC_LEFT, SC_PREFIX, SC_NONE, SC_UP,
			SC_PREFIX, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15, 8'h16};
		wait_input_drained();

		run_phase(0, 0, 220);
		run_phase(45, 0, 220);
		run_phase(0, 45, 220);
		run_phase(14, 14, 220);

		// receiver holds off while the sender keeps offering
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		add_keyboard_traffic(50);
		@(posedge clk);
		receiver_hold = 1'b1;
		repeat (HOLD_OFF_CYCLES) @(posedge clk);
		receiver_hold = 1'b0;
		wait_input_drained();

		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
